### design/cssc_pkg.sv
// ----------------------------------------------------------------------------
// cssc_pkg: shared definitions for the C source scanner with checksum
// Character codes, include-match step codes and the per-byte scan result.
// ----------------------------------------------------------------------------
package cssc_pkg;

    localparam int LINE_MAX_DEF = 256;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Include keyword matcher: IDLE, then one step per keyword letter,
    // NAME while the file name is parsed, DEAD when the line cannot match.
    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_FIRST = 4'd1;
    localparam logic [3:0] STEP_LAST  = 4'd7;
    localparam logic [3:0] STEP_NAME  = 4'd8;
    localparam logic [3:0] STEP_DEAD  = 4'd15;

    localparam int DATA_OUT_W = 88;

    typedef struct packed {
        logic       in_comment;
        logic       in_literal;
        logic       in_directive;
        logic       include_found;
        logic [7:0] name_start;
        logic [7:0] name_length;
    } scan_res_t;

    // Letter expected at a given keyword step.
    function automatic logic [7:0] keyword_char(input logic [3:0] step);
        logic [7:0] ch;
        begin
            case (step)
                4'd1:    ch = 8'h69; // i
                4'd2:    ch = 8'h6E; // n
                4'd3:    ch = 8'h63; // c
                4'd4:    ch = 8'h6C; // l
                4'd5:    ch = 8'h75; // u
                4'd6:    ch = 8'h64; // d
                4'd7:    ch = 8'h65; // e
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

### design/cssc_scan.sv
// ----------------------------------------------------------------------------
// cssc_scan: lexical state tracker and include-name parser
// Holds the per-line scanner state, classifies each byte and reports the
// include file name position when a newline closes an include line.
// ----------------------------------------------------------------------------
module cssc_scan
    import cssc_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] char_byte,
    input  logic       end_of_file,
    output logic [7:0] char_eff,
    output scan_res_t  res
);

    localparam int LP_W = $clog2(LINE_MAX + 1);
    localparam int PW   = (LP_W > 8) ? LP_W : 8;

    logic            blk_reg, ln_reg, str_reg, chr_reg, dir_reg, first_reg;
    logic            blk_next, ln_next, str_next, chr_next, dir_next, first_next;
    logic [7:0]      prev_reg;
    logic [LP_W-1:0] lpos_reg, lpos_next;
    logic [3:0]      step_reg, step_next;
    logic            np_cmt_reg, np_name_reg, np_done_reg;
    logic            np_cmt_next, np_name_next, np_done_next;
    logic [7:0]      first_pos_reg, first_pos_next;
    logic [7:0]      last_pos_reg, last_pos_next;
    logic [7:0]      nprev_reg, nprev_next;

    logic [PW-1:0]   pos_ext;
    logic [7:0]      pos8;
    logic [7:0]      c;
    logic            busy;
    logic            found;

    assign pos_ext  = PW'(lpos_reg);
    assign pos8     = pos_ext[7:0];
    assign c        = (prev_reg == CH_BACKSLASH) ? CH_SPACE : char_byte;
    assign char_eff = c;
    assign busy     = blk_reg | ln_reg | str_reg | chr_reg;

    always_comb begin
        blk_next       = blk_reg;
        ln_next        = ln_reg;
        str_next       = str_reg;
        chr_next       = chr_reg;
        dir_next       = dir_reg;
        first_next     = first_reg;
        lpos_next      = lpos_reg;
        step_next      = step_reg;
        np_cmt_next    = np_cmt_reg;
        np_name_next   = np_name_reg;
        np_done_next   = np_done_reg;
        first_pos_next = first_pos_reg;
        last_pos_next  = last_pos_reg;
        nprev_next     = nprev_reg;
        found          = 1'b0;

        // A line longer than the limit freezes its position and kills the match.
        if (lpos_reg >= LP_W'(LINE_MAX)) begin
            step_next = STEP_DEAD;
        end else begin
            lpos_next = lpos_reg + 1'b1;
        end

        if (step_next >= STEP_FIRST && step_next <= STEP_LAST) begin
            if (c == keyword_char(step_next)) begin
                step_next = step_next + 1'b1;
            end else begin
                step_next = STEP_DEAD;
            end
        end else if (step_next == STEP_NAME && !np_done_reg) begin
            case (c)
                CH_SLASH: begin
                    if (np_cmt_reg && nprev_reg == CH_STAR) np_cmt_next = 1'b0;
                end
                CH_STAR: begin
                    if (!np_cmt_reg && nprev_reg == CH_SLASH) np_cmt_next = 1'b1;
                end
                CH_LT: begin
                    if (!np_cmt_reg) begin
                        np_name_next   = 1'b1;
                        first_pos_next = pos8 + 8'd1;
                    end
                end
                CH_GT: begin
                    if (np_name_reg) begin
                        np_done_next  = 1'b1;
                        last_pos_next = pos8 - 8'd1;
                    end
                end
                CH_DQUOTE: begin
                    if (!np_cmt_reg) begin
                        if (!np_name_reg) begin
                            np_name_next   = 1'b1;
                            first_pos_next = pos8 + 8'd1;
                        end else begin
                            np_done_next  = 1'b1;
                            last_pos_next = pos8 - 8'd1;
                        end
                    end
                end
                default: ;
            endcase
            nprev_next = c;
        end

        case (c)
            CH_SLASH: begin
                if (blk_reg && prev_reg == CH_STAR) begin
                    blk_next = 1'b0;
                end else if (!busy && prev_reg == CH_SLASH) begin
                    ln_next = 1'b1;
                end
            end
            CH_DQUOTE: begin
                if (!busy) str_next = 1'b1;
                else if (str_reg) str_next = 1'b0;
            end
            CH_STAR: begin
                if (!busy && prev_reg == CH_SLASH) blk_next = 1'b1;
            end
            CH_SQUOTE: begin
                if (!busy) chr_next = 1'b1;
                else if (chr_reg) chr_next = 1'b0;
            end
            CH_HASH: begin
                if (first_reg) begin
                    dir_next = 1'b1;
                    if (step_next == STEP_IDLE) step_next = STEP_FIRST;
                end
            end
            CH_NEWLINE: begin
                ln_next    = 1'b0;
                first_next = 1'b1;
                if (dir_reg) begin
                    dir_next = 1'b0;
                    found    = (step_next == STEP_NAME) && np_done_next;
                end
            end
            default: ;
        endcase

        if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_NEWLINE) begin
            first_next = 1'b0;
        end

        res.in_comment    = blk_next | ln_next;
        res.in_literal    = str_next | chr_next;
        res.in_directive  = dir_next;
        res.include_found = found;
        res.name_start    = found ? first_pos_next : 8'd0;
        res.name_length   = found ? (last_pos_next + 8'd1 - first_pos_next) : 8'd0;

        if (c == CH_NEWLINE) begin
            lpos_next      = '0;
            step_next      = STEP_IDLE;
            np_cmt_next    = 1'b0;
            np_name_next   = 1'b0;
            np_done_next   = 1'b0;
            first_pos_next = 8'd0;
            last_pos_next  = 8'd0;
            nprev_next     = CH_SPACE;
        end
    end

    // The last byte of a file returns everything to the reset state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && end_of_file)) begin
            blk_reg       <= 1'b0;
            ln_reg        <= 1'b0;
            str_reg       <= 1'b0;
            chr_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            first_reg     <= 1'b1;
            prev_reg      <= CH_SPACE;
            lpos_reg      <= '0;
            step_reg      <= STEP_IDLE;
            np_cmt_reg    <= 1'b0;
            np_name_reg   <= 1'b0;
            np_done_reg   <= 1'b0;
            first_pos_reg <= 8'd0;
            last_pos_reg  <= 8'd0;
            nprev_reg     <= CH_SPACE;
        end else if (step_en) begin
            blk_reg       <= blk_next;
            ln_reg        <= ln_next;
            str_reg       <= str_next;
            chr_reg       <= chr_next;
            dir_reg       <= dir_next;
            first_reg     <= first_next;
            prev_reg      <= c;
            lpos_reg      <= lpos_next;
            step_reg      <= step_next;
            np_cmt_reg    <= np_cmt_next;
            np_name_reg   <= np_name_next;
            np_done_reg   <= np_done_next;
            first_pos_reg <= first_pos_next;
            last_pos_reg  <= last_pos_next;
            nprev_reg     <= nprev_next;
        end
    end

endmodule

### design/c_source_scanner_checksum.sv
// ----------------------------------------------------------------------------
// c_source_scanner_checksum: C source byte scanner with file checksum
//
//   channel  | direction | tdata                                | tlast
//   ---------+-----------+--------------------------------------+---------------
//   s_       | in        | char_byte                            | end_of_file
//   m_       | out       | flags, name_start, name_length, sum  | checksum_valid
//
// One byte per clock while the output is not stalled; each accepted byte yields one result in the next cycle.
// The scanner state and checksum update in the same cycle the byte is taken,
// and the result is held in a single output register.
// A new byte is taken whenever the output register is empty or being drained.
// aresetn is synchronous and active low; the last byte of a file also returns
// all scanner and checksum state to reset.
// ----------------------------------------------------------------------------
module c_source_scanner_checksum
    import cssc_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] char_byte
    input  logic                  s_tlast,  // end_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] in_comment, [1] in_literal, [2] in_directive, [3] include_found,
    // [11:4] name_start, [19:12] name_length, [83:20] file_checksum, rest zero
    output logic [DATA_OUT_W-1:0] m_tdata,
    output logic                  m_tlast   // checksum_valid
);

    logic                  accept;
    logic [7:0]            char_eff;
    scan_res_t             res;

    logic [63:0]           acc_reg, acc_next;
    logic [63:0]           wbuf_reg, wbuf_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [63:0]           sum;
    logic [63:0]           file_checksum;

    logic                  mvalid_reg;
    logic [DATA_OUT_W-1:0] mdata_reg, mdata_next;
    logic                  mlast_reg;

    assign s_tready = !mvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    cssc_scan #(
        .LINE_MAX (LINE_MAX)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (accept),
        .char_byte   (s_tdata),
        .end_of_file (s_tlast),
        .char_eff    (char_eff),
        .res         (res)
    );

    // A full word folds into the accumulator; at end of file a partly
    // refilled buffer is folded in as it stands.
    assign wbuf_next     = {wbuf_reg[55:0], char_eff};
    assign cnt_next      = cnt_reg + 3'd1;
    assign acc_next      = (cnt_reg == 3'd7) ? (acc_reg ^ wbuf_next) : acc_reg;
    assign sum           = (cnt_next != 3'd0) ? (acc_next ^ wbuf_next) : acc_next;
    assign file_checksum = s_tlast ? sum : 64'd0;

    assign mdata_next = {4'd0, file_checksum, res.name_length, res.name_start,
                         res.include_found, res.in_directive, res.in_literal,
                         res.in_comment};

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            acc_reg  <= 64'd0;
            wbuf_reg <= 64'd0;
            cnt_reg  <= 3'd0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            wbuf_reg <= wbuf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (accept) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mdata_reg <= mdata_next;
            mlast_reg <= s_tlast;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

`ifndef SYNTH
    // An include report only comes on the newline that ends the directive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("include reported while still on a directive line");

    // The checksum field is zero except on the last result of a file.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[83:20] == 64'd0)
        else $error("checksum present on a result that is not end of file");

    // Checksum state starts fresh after the last byte of a file.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> cnt_reg == 3'd0 && acc_reg == 64'd0 && wbuf_reg == 64'd0)
        else $error("checksum state not cleared after end of file");
`endif

endmodule

### tb/sv/tb_c_source_scanner_checksum.sv
// ----------------------------------------------------------------------------
// tb_c_source_scanner_checksum: self-checking bench for the C source scanner
// Streams short C-like files byte by byte through the block. A scoreboard
// predicts the classification flags, include name reports and file checksum
// of every byte and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_c_source_scanner_checksum
    import cssc_pkg::*;
();

    localparam int LINE_LIMIT     = LINE_MAX_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 64;
    // Keyword after '#', first letter in the top byte.
    localparam logic [55:0] INCLUDE_WORD = "include";

    typedef struct {
        logic        in_comment;
        logic        in_literal;
        logic        in_directive;
        logic        include_found;
        logic [7:0]  name_start;
        logic [7:0]  name_length;
        logic        checksum_valid;
        logic [63:0] file_checksum;
    } scan_expect_t;

    class scan_scoreboard;
        scan_expect_t expected_scans[$];
        int           errors;

        logic [63:0] sum_acc;
        logic [63:0] shift_word;
        logic [2:0]  word_fill;
        logic        in_block, in_line, in_string, in_char, on_directive, at_line_start;
        logic [7:0]  last_char;
        int unsigned col;
        logic [3:0]  kw_step;
        logic        name_in_comment, name_open, name_closed;
        int unsigned name_lo, name_hi;
        logic [7:0]  name_last_char;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void clear_line();
            col             = 0;
            kw_step         = STEP_IDLE;
            name_in_comment = 1'b0;
            name_open       = 1'b0;
            name_closed     = 1'b0;
            name_lo         = 0;
            name_hi         = 0;
            name_last_char  = CH_SPACE;
        endfunction

        function void reset_state();
            sum_acc       = '0;
            shift_word    = '0;
            word_fill     = '0;
            in_block      = 1'b0;
            in_line       = 1'b0;
            in_string     = 1'b0;
            in_char       = 1'b0;
            on_directive  = 1'b0;
            at_line_start = 1'b1;
            last_char     = CH_SPACE;
            clear_line();
        endfunction

        function void parse_name(logic [7:0] c, int unsigned pos);
            if (name_closed)
                return;
            case (c)
                CH_SLASH: begin
                    if (name_in_comment && name_last_char == CH_STAR)
                        name_in_comment = 1'b0;
                end
                CH_STAR: begin
                    if (!name_in_comment && name_last_char == CH_SLASH)
                        name_in_comment = 1'b1;
                end
                CH_LT: begin
                    if (!name_in_comment) begin
                        name_open = 1'b1;
                        name_lo   = pos + 1;
                    end
                end
                // A closing angle ends the name even inside a comment.
                CH_GT: begin
                    if (name_open) begin
                        name_closed = 1'b1;
                        name_hi     = pos - 1;
                    end
                end
                CH_DQUOTE: begin
                    if (!name_in_comment) begin
                        if (!name_open) begin
                            name_open = 1'b1;
                            name_lo   = pos + 1;
                        end else begin
                            name_closed = 1'b1;
                            name_hi     = pos - 1;
                        end
                    end
                end
                default: ;
            endcase
            name_last_char = c;
        endfunction

        function void note_byte(logic [7:0] raw, logic eof);
            logic [7:0]   c;
            int unsigned  pos;
            int           k;
            logic         busy;
            scan_expect_t e;
            e.include_found = 1'b0;
            e.name_start    = '0;
            e.name_length   = '0;
            // Anything after a backslash is taken as a space.
            c   = (last_char == CH_BACKSLASH) ? CH_SPACE : raw;
            pos = col;
            if (col >= LINE_LIMIT)
                kw_step = STEP_DEAD;
            else
                col++;

            if (kw_step >= STEP_FIRST && kw_step <= STEP_LAST) begin
                k = kw_step - 1;
                if (c == INCLUDE_WORD[55 - 8 * k -: 8])
                    kw_step = kw_step + 4'd1;
                else
                    kw_step = STEP_DEAD;
            end else if (kw_step == STEP_NAME) begin
                parse_name(c, pos);
            end

            busy = in_block | in_line | in_string | in_char;
            case (c)
                CH_SLASH: begin
                    if (in_block && last_char == CH_STAR)
                        in_block = 1'b0;
                    else if (!busy && last_char == CH_SLASH)
                        in_line = 1'b1;
                end
                CH_DQUOTE: begin
                    if (!busy)
                        in_string = 1'b1;
                    else if (in_string)
                        in_string = 1'b0;
                end
                CH_STAR: begin
                    if (!busy && last_char == CH_SLASH)
                        in_block = 1'b1;
                end
                CH_SQUOTE: begin
                    if (!busy)
                        in_char = 1'b1;
                    else if (in_char)
                        in_char = 1'b0;
                end
                CH_HASH: begin
                    if (at_line_start) begin
                        on_directive = 1'b1;
                        if (kw_step == STEP_IDLE)
                            kw_step = STEP_FIRST;
                    end
                end
                CH_NEWLINE: begin
                    in_line       = 1'b0;
                    at_line_start = 1'b1;
                    if (on_directive) begin
                        on_directive = 1'b0;
                        if (kw_step == STEP_NAME && name_closed) begin
                            e.include_found = 1'b1;
                            e.name_start    = 8'(name_lo);
                            e.name_length   = 8'(name_hi + 1 - name_lo);
                        end
                    end
                    clear_line();
                end
                default: ;
            endcase
            if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_NEWLINE)
                at_line_start = 1'b0;

            shift_word = {shift_word[55:0], c};
            word_fill  = word_fill + 3'd1;
            if (word_fill == 3'd0)
                sum_acc = sum_acc ^ shift_word;
            last_char = c;

            e.in_comment     = in_block | in_line;
            e.in_literal     = in_string | in_char;
            e.in_directive   = on_directive;
            e.checksum_valid = eof;
            e.file_checksum  = '0;
            if (eof) begin
                e.file_checksum = (word_fill != 3'd0) ? (sum_acc ^ shift_word) : sum_acc;
                reset_state();
            end
            expected_scans.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [DATA_OUT_W-1:0] data, logic last);
            scan_expect_t e;
            if (expected_scans.size() == 0) begin
                $error("result transaction with no byte outstanding");
                errors++;
                return;
            end
            e = expected_scans.pop_front();
            compare_field("in_comment", 64'(e.in_comment), 64'(data[0]));
            compare_field("in_literal", 64'(e.in_literal), 64'(data[1]));
            compare_field("in_directive", 64'(e.in_directive), 64'(data[2]));
            compare_field("include_found", 64'(e.include_found), 64'(data[3]));
            compare_field("name_start", 64'(e.name_start), 64'(data[11:4]));
            compare_field("name_length", 64'(e.name_length), 64'(data[19:12]));
            compare_field("checksum_valid", 64'(e.checksum_valid), 64'(last));
            compare_field("file_checksum", e.file_checksum, data[83:20]);
        endfunction

        function int pending_count();
            return expected_scans.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;
    logic                  m_tlast;

    scan_scoreboard sb;
    logic [7:0]     file_bytes[$];
    int             tx_idle_pct = 38;
    int             rx_idle_pct = 56;
    int             files_made  = 0;
    logic           hold_request = 1'b0;
    logic           hold_taken   = 1'b0;
    int             hold_left    = 0;
    int             quiet_cycles = 0;

    c_source_scanner_checksum #(.LINE_MAX(LINE_LIMIT)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Receiver: random back-pressure, plus one long hold counted here.
    always @(posedge aclk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function void add_char(logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function void add_name(int n);
        string chars;
        chars = "abcxyzXYZ0189_./-*<\"";
        for (int i = 0; i < n; i++)
            add_char(chars[$urandom_range(chars.len() - 1)]);
    endfunction

    function void add_include_line();
        logic angled;
        angled = 1'($urandom_range(1));
        repeat ($urandom_range(2))
            add_char($urandom_range(1) ? CH_SPACE : CH_TAB);
        add_text("#include");
        repeat ($urandom_range(3))
            add_char(CH_SPACE);
        case ($urandom_range(5))
            0: add_text("/* <x> */");
            1: add_text("/*\"q\"*/");
            2: add_text("/**/");
            default: ;
        endcase
        add_char(angled ? CH_LT : CH_DQUOTE);
        add_name($urandom_range(12));
        // Now and then the name is never closed.
        if ($urandom_range(9) != 0)
            add_char(angled ? CH_GT : CH_DQUOTE);
        if ($urandom_range(3) == 0)
            add_text(" // tail");
        add_char(CH_NEWLINE);
    endfunction

    // Name placed far into the line when far is set, so the offsets use their upper bits.
    function void add_wide_include(logic far);
        int gap;
        int len;
        gap = far ? $urandom_range(118, 200) : $urandom_range(0, 60);
        len = $urandom_range(0, 240 - gap);
        add_text("#include");
        repeat (gap)
            add_char(CH_SPACE);
        add_char(CH_LT);
        repeat (len)
            add_char(8'("a" + $urandom_range(25)));
        add_char(CH_GT);
        add_char(CH_NEWLINE);
    endfunction

    // Include line padded to an exact length, newline counted.
    function void add_padded_include(int total);
        add_text("#include <x>");
        repeat (total - 13)
            add_char(CH_SPACE);
        add_char(CH_NEWLINE);
    endfunction

    function void add_directive_line();
        case ($urandom_range(6))
            0: add_text("#define N '\\''");
            1: add_text("# include <a.h>");
            2: add_text("#inclde <a.h>");
            3: add_text("#includes <b.h>");
            4: add_text("#include\t<c.h> /* x");
            5: add_text("  #pragma once");
            default: add_text("x #include <d.h>");
        endcase
        add_char(CH_NEWLINE);
    endfunction

    function void add_code_token();
        case ($urandom_range(13))
            0:  add_text("int x = 1;");
            1:  add_text("\"text\"");
            2:  add_text("\"a\\\"b\"");
            3:  add_text("'c'");
            4:  add_text("'\\''");
            5:  add_text("/* note */");
            6:  add_text("// rest");
            7:  add_text("/*");
            8:  add_text("*/");
            9:  add_text("\\");
            10: add_text("a/b*c");
            11: add_text(" # ");
            12: add_text("'");
            default: add_text("\"");
        endcase
    endfunction

    function void add_line();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            add_include_line();
        end else if (pick < 31) begin
            add_wide_include(1'($urandom_range(1)));
        end else if (pick < 43) begin
            add_directive_line();
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 5))
                add_code_token();
            add_char(CH_NEWLINE);
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 20))
                add_char(8'($urandom_range(255)));
            if ($urandom_range(1))
                add_char(CH_NEWLINE);
        end else begin
            if ($urandom_range(1))
                add_text(" \t\r\n");
            else
                add_text("\n");
        end
    endfunction

    function void build_file();
        files_made++;
        if (files_made == 3)
            add_padded_include(LINE_LIMIT);
        if (files_made == 6)
            add_padded_include(LINE_LIMIT + 1);
        repeat ($urandom_range(1, 12))
            add_line();
        if ($urandom_range(1))
            repeat ($urandom_range(1, 3))
                add_code_token();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_file(inout int sent);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        sent += file_bytes.size();
        file_bytes.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int byte_goal);
        int sent;
        sent        = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < byte_goal) begin
            build_file();
            send_file(sent);
        end
    endtask

    initial begin
        int sent;
        sent = 0;
        sb   = new();
        repeat (7)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty quoted name, with the report on the last byte of the file.
        add_text("#include\"\"\n");
        send_file(sent);
        // Char literal with an escaped quote, block and line comments,
        // and the byte extremes, zero byte included.
        add_text("'\\''/*x*///");
        add_char(8'h00);
        add_char(8'hFF);
        send_file(sent);
        wait_drained();

        // Each phase ends on a whole file, so it runs somewhat past its goal.
        run_phase(38, 56, 360);
        wait_drained();
        run_phase(56, 38, 360);
        wait_drained();
        hold_request = 1'b1;
        run_phase(0, 0, 400);
        wait_drained();
        repeat (4)
            @(posedge aclk);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
